@@ hw/rtl/markup_node_splitter_core_defines.svh @@
// Assertion macros for the markup node splitter RTL.
`ifndef MARKUP_NODE_SPLITTER_CORE_DEFINES_SVH
`define MARKUP_NODE_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define MNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define MNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mns_pkg.sv @@
// Shared types, constants and helpers for the markup node splitter.
package mns_pkg;

    localparam longint unsigned MAX_SPAN = 65535;
    localparam int CNT_W = $clog2(MAX_SPAN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPAN);
    localparam int FIELD_W = 16;

    localparam logic [1:0] K_TEXT = 2'd0;
    localparam logic [1:0] K_TAG  = 2'd1;
    localparam logic [1:0] K_COMM = 2'd2;
    localparam logic [1:0] K_END  = 2'd3;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] span;
        logic               ok;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/mns_scanner.sv @@
// Byte scanner: node state machine, counters and result generation.
module mns_scanner (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    char_in,
    input  logic          buffer_end,
    output mns_pkg::push_t push
);
    import mns_pkg::*;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_TEXT  = 4'd1;
    localparam logic [3:0] M_LT    = 4'd2;
    localparam logic [3:0] M_BANG  = 4'd3;
    localparam logic [3:0] M_DASH1 = 4'd4;
    localparam logic [3:0] M_TAG   = 4'd5;
    localparam logic [3:0] M_CB0   = 4'd6;
    localparam logic [3:0] M_CB1   = 4'd7;
    localparam logic [3:0] M_CB2   = 4'd8;
    localparam logic [3:0] M_CBWS  = 4'd9;

    logic [3:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] begin_reg, begin_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < MAX_CNT) ? v + CNT_W'(1) : MAX_CNT;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic push_t emit(input push_t p, input logic [1:0] kind,
                                   input logic [FIELD_W-1:0] start,
                                   input logic [FIELD_W-1:0] span, input logic ok);
        push_t q;
        res_t  r;
        q = p;
        r.kind  = kind;
        r.start = start;
        r.span  = span;
        r.ok    = ok;
        r.last  = 1'b0;
        if (p.n == 2'd0) begin
            q.r0 = r;
        end else begin
            q.r1 = r;
        end
        q.n = p.n + 2'd1;
        return q;
    endfunction

    always_comb begin
        logic [3:0]       nx;
        logic             closed;
        logic [1:0]       close_kind;
        logic [CNT_W-1:0] cnt_inc;
        push_t            p;

        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        nx         = mode_reg;
        closed     = 1'b0;
        close_kind = K_TAG;
        cnt_inc    = sat_inc(cnt_reg);
        p          = '0;

        if (accept) begin
            if (mode_reg == M_IDLE) begin
                begin_next = pos_reg;
                cnt_next   = CNT_W'(1);
                mode_next  = (char_in == CH_LT) ? M_LT : M_TEXT;
            end else if (mode_reg == M_TEXT && char_in == CH_LT) begin
                p = emit(p, K_TEXT, to_field(begin_reg), to_field(cnt_reg), 1'b0);
                begin_next = pos_reg;
                cnt_next   = CNT_W'(1);
                mode_next  = M_LT;
            end else begin
                cnt_next = cnt_inc;
                case (mode_reg)
                    M_TEXT: begin
                        nx = M_TEXT;
                    end
                    M_LT, M_BANG, M_DASH1: begin
                        if (char_in == CH_GT) begin
                            closed = 1'b1;
                        end else if (mode_reg == M_LT && char_in == CH_BANG) begin
                            nx = M_BANG;
                        end else if (mode_reg == M_BANG && char_in == CH_DASH) begin
                            nx = M_DASH1;
                        end else if (mode_reg == M_DASH1 && char_in == CH_DASH) begin
                            nx = M_CB0;
                        end else begin
                            nx = M_TAG;
                        end
                    end
                    M_TAG: begin
                        if (char_in == CH_GT) begin
                            closed = 1'b1;
                        end
                    end
                    M_CB0: begin
                        if (char_in == CH_DASH) begin
                            nx = M_CB1;
                        end
                    end
                    M_CB1: begin
                        nx = (char_in == CH_DASH) ? M_CB2 : M_CB0;
                    end
                    M_CB2: begin
                        if (char_in == CH_GT) begin
                            closed     = 1'b1;
                            close_kind = K_COMM;
                        end else if (char_in == CH_DASH) begin
                            nx = M_CB2;
                        end else if (is_ws(char_in)) begin
                            nx = M_CBWS;
                        end else begin
                            nx = M_CB0;
                        end
                    end
                    default: begin
                        if (char_in == CH_GT) begin
                            closed     = 1'b1;
                            close_kind = K_COMM;
                        end else if (char_in == CH_DASH) begin
                            nx = M_CB1;
                        end else if (!is_ws(char_in)) begin
                            nx = M_CB0;
                        end
                    end
                endcase
                if (closed) begin
                    p = emit(p, close_kind, to_field(begin_reg), to_field(cnt_inc), 1'b0);
                    nx       = M_IDLE;
                    cnt_next = '0;
                end
                mode_next = nx;
            end

            pos_next = sat_inc(pos_reg);

            if (buffer_end) begin
                if (mode_next == M_TEXT) begin
                    p = emit(p, K_TEXT, to_field(begin_next), to_field(cnt_next), 1'b0);
                    mode_next = M_IDLE;
                end
                if (mode_next == M_IDLE) begin
                    p = emit(p, K_END, to_field(pos_next), '0, 1'b1);
                end else begin
                    p = emit(p, K_END, to_field(begin_next), to_field(cnt_next), 1'b0);
                end
                mode_next  = M_IDLE;
                cnt_next   = '0;
                pos_next   = '0;
                begin_next = '0;
            end

            if (p.n == 2'd2) begin
                p.r1.last = 1'b1;
            end else if (p.n == 2'd1) begin
                p.r0.last = 1'b1;
            end
        end
        push = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
        end
    end

endmodule

@@ hw/rtl/mns_out_fifo.sv @@
// Four-entry result queue taking up to two results per cycle.
module mns_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  mns_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output mns_pkg::res_t  head
);
    import mns_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (level_reg <= LVL_W'(DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push.n) - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

@@ hw/rtl/markup_node_splitter_core.sv @@
// Top level of the markup node splitter: byte stream in, node records out.
// The block takes one byte of a markup buffer per request and reports text,
// tag and comment nodes with their start offset and length, followed on the
// final byte of each buffer by an end record giving the incomplete tail.
// Each byte is scanned in the cycle it is accepted and its results, up to two,
// go into a four-entry output queue, so its first result is held there from the
// next cycle and a byte can be accepted every cycle while the queue has two
// free entries. The final byte of a buffer yields two records when it also
// ends a text node or closes a tag or comment, and the output side then presents
// them one at a time. Offsets restart at zero after each buffer end.
`include "markup_node_splitter_core_defines.svh"

module markup_node_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] char_in
    input  logic        s_tlast,  // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [15:0] start_offset, [31:16] span, [32] whole_ok, zero pad
    output logic [1:0]  m_tuser,  // [1:0] kind
    output logic        m_tlast   // run_last
);
    import mns_pkg::*;

    logic  accept;
    logic  room;
    push_t push;
    res_t  head;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    mns_scanner u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .char_in    (s_tdata),
        .buffer_end (s_tlast),
        .push       (push)
    );

    mns_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {7'b0, head.ok, head.span, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `MNS_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser == K_END, m_tlast, "end record not marked last")
    `MNS_ASSERT_NOW(a_ok_only_end, m_tvalid && m_tdata[32], m_tuser == K_END, "whole_ok on a node record")
    `MNS_ASSERT_NOW(a_ok_zero_span, m_tvalid && m_tdata[32], m_tdata[31:16] == 16'd0, "complete buffer with non-zero tail")
    `MNS_ASSERT_NOW(a_no_overfill, !s_tready, push.n == 2'd0, "results pushed while full")

endmodule
